>>> rtl/core/mwpo_pkg.sv
// package for the multi-waveform phase oscillator
// holds shared widths, codes, the pipeline stage struct and the sine table builder
// no dependencies
`timescale 1ns / 1ps

package mwpo_pkg;

   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int PHASE_BITS_DEF      = 32;
   localparam int SAMPLE_BITS_DEF     = 16;

   localparam int FREQ_STEP_W       = 32;
   localparam int PHASE_OFFSET_W    = 16;
   localparam int PULSE_THRESHOLD_W = 17;
   localparam int TURN_W            = 32;
   localparam int WAVE_MODE_W       = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 3;

   localparam logic [CSR_ADDR_W-3:0] CSR_WAVE_MODE_IDX = '0;

   typedef enum logic [WAVE_MODE_W-1:0] {
      WAVE_SINE     = 3'd0,
      WAVE_TRIANGLE = 3'd1,
      WAVE_RISE_SAW = 3'd2,
      WAVE_FALL_SAW = 3'd3,
      WAVE_SQUARE   = 3'd4
   } wave_mode_type;

   // phase stage handed to the shaper
   typedef struct packed {
      logic                         valid;
      logic [TURN_W-1:0]            turn;
      logic [PULSE_THRESHOLD_W-1:0] thr;
   } mwpo_stage_type;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // sin(x) for x in [0, pi/2], q30, taylor series to x^13 in horner form
   function automatic logic [63:0] sine_q30(logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] acc;
      logic [63:0] prod;
      x2   = (x * x) >> 30;
      acc  = Q30_ONE;
      prod = ((x2 * acc) >> 30) / 156;
      acc  = (prod >= Q30_ONE) ? 64'd0 : Q30_ONE - prod;
      prod = ((x2 * acc) >> 30) / 110;
      acc  = (prod >= Q30_ONE) ? 64'd0 : Q30_ONE - prod;
      prod = ((x2 * acc) >> 30) / 72;
      acc  = (prod >= Q30_ONE) ? 64'd0 : Q30_ONE - prod;
      prod = ((x2 * acc) >> 30) / 42;
      acc  = (prod >= Q30_ONE) ? 64'd0 : Q30_ONE - prod;
      prod = ((x2 * acc) >> 30) / 20;
      acc  = (prod >= Q30_ONE) ? 64'd0 : Q30_ONE - prod;
      prod = ((x2 * acc) >> 30) / 6;
      acc  = (prod >= Q30_ONE) ? 64'd0 : Q30_ONE - prod;
      return (x * acc) >> 30;
   endfunction

   // quarter-wave table entry k, rounded and clamped to full scale
   function automatic logic [31:0] sine_entry(int k, int tbl_bits, int sample_bits);
      logic [63:0] full;
      logic [63:0] ang;
      logic [63:0] s;
      logic [63:0] v;
      full = 64'd1 << (sample_bits - 1);
      ang  = (HALF_PI_Q30 * 64'(k)) >> tbl_bits;
      s    = sine_q30(ang);
      v    = (s * full + (64'd1 << 29)) >> 30;
      if (v > full) begin
         v = full;
      end
      return v[31:0];
   endfunction

endpackage

>>> rtl/core/mwpo_if.sv
// request and response channel interfaces of the phase oscillator
// depends on mwpo_pkg
`timescale 1ns / 1ps

interface mwpo_req_if import mwpo_pkg::*;;
   logic                                valid;
   logic                                ready;
   logic signed [FREQ_STEP_W-1:0]       freq_step;
   logic        [PHASE_OFFSET_W-1:0]    phase_offset;
   logic        [PULSE_THRESHOLD_W-1:0] pulse_threshold;
   logic                                restart;

   modport source (output valid, freq_step, phase_offset, pulse_threshold, restart,
                   input ready);
   modport sink   (input valid, freq_step, phase_offset, pulse_threshold, restart,
                   output ready);
endinterface

interface mwpo_rsp_if import mwpo_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

>>> rtl/core/mwpo_csr.sv
// configuration register block: apb-style write and read of wave_mode
// depends on mwpo_pkg
`timescale 1ns / 1ps

module mwpo_csr import mwpo_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready,
   output logic [WAVE_MODE_W-1:0] wave_mode
);

   logic [WAVE_MODE_W-1:0]  wave_mode_ff;
   logic [WAVE_MODE_W-1:0]  wave_mode_in;
   logic [CSR_ADDR_W-3:0]   reg_index;
   logic                    wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      wave_mode_in = wave_mode_ff;
      if (wr_en && (reg_index == CSR_WAVE_MODE_IDX)) begin
         wave_mode_in = pwdata[WAVE_MODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff <= WAVE_SINE;
      end else begin
         wave_mode_ff <= wave_mode_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == CSR_WAVE_MODE_IDX) begin
         prdata = {{(CSR_DATA_W-WAVE_MODE_W){1'b0}}, wave_mode_ff};
      end
   end

   assign wave_mode = wave_mode_ff;

endmodule

>>> rtl/core/mwpo_phase.sv
// phase accumulator and input register stage
// depends on mwpo_pkg and mwpo_if
`timescale 1ns / 1ps

module mwpo_phase import mwpo_pkg::*; #(
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   mwpo_req_if.sink       req_chan,
   input  logic           advance,
   output mwpo_stage_type stage
);

   logic [PHASE_BITS-1:0] acc_ff;
   logic [PHASE_BITS-1:0] acc_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic [TURN_W-1:0]     turn_ff;
   logic [PULSE_THRESHOLD_W-1:0] thr_ff;

   logic                  accept;
   logic [PHASE_BITS-1:0] acc_base;
   logic [PHASE_BITS-1:0] off_al;
   logic [PHASE_BITS-1:0] step_al;
   logic [PHASE_BITS-1:0] phase_sum;
   logic [PHASE_BITS+PHASE_OFFSET_W-1:0] off_ext;
   logic [PHASE_BITS+FREQ_STEP_W-1:0]    step_ext;
   logic [PHASE_BITS+TURN_W-1:0]         phase_ext;
   logic [TURN_W-1:0]                    turn_in;

   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   // align offset and step to the accumulator: scale by 2^PHASE_BITS, drop the field width
   assign off_ext  = {req_chan.phase_offset, {PHASE_BITS{1'b0}}};
   assign off_al   = off_ext[PHASE_BITS+PHASE_OFFSET_W-1 -: PHASE_BITS];
   assign step_ext = {req_chan.freq_step, {PHASE_BITS{1'b0}}};
   assign step_al  = step_ext[PHASE_BITS+FREQ_STEP_W-1 -: PHASE_BITS];

   assign acc_base  = req_chan.restart ? '0 : acc_ff;
   assign phase_sum = acc_base + off_al;

   // 32-bit turn view of the phase
   assign phase_ext = {phase_sum, {TURN_W{1'b0}}};
   assign turn_in   = phase_ext[PHASE_BITS+TURN_W-1 -: TURN_W];

   always_comb begin
      acc_in   = acc_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = accept;
      end
      if (accept) begin
         acc_in = acc_base + step_al;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         turn_ff <= turn_in;
         thr_ff  <= req_chan.pulse_threshold;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.turn  = turn_ff;
   assign stage.thr   = thr_ff;

endmodule

>>> rtl/core/mwpo_shape.sv
// waveform shaper: sine rom lookup, triangle, saws and square, then output stage
// depends on mwpo_pkg
`timescale 1ns / 1ps

module mwpo_shape import mwpo_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mwpo_stage_type                stage,
   input  logic                          advance,
   input  logic [WAVE_MODE_W-1:0]        wave_mode,
   output logic                          out_valid,
   output logic signed [SAMPLE_BITS-1:0] out_sample
);

   localparam int TBL_N = 1 << SINE_TABLE_BITS;
   localparam int RW    = SAMPLE_BITS + 1;
   localparam int VW    = SAMPLE_BITS + 2;
   localparam logic [SINE_TABLE_BITS:0] TBL_N_V = (SINE_TABLE_BITS + 1)'(TBL_N);
   localparam logic signed [VW-1:0] FULL_V = VW'(64'd1 << (SAMPLE_BITS - 1));
   localparam logic signed [VW-1:0] MAX_V  = FULL_V - VW'(1);

   logic [RW-1:0] sine_rom [0:TBL_N];

   logic [1:0]                   quad;
   logic [SINE_TABLE_BITS-1:0]   idx;
   logic [SINE_TABLE_BITS:0]     pos;
   logic [SAMPLE_BITS-1:0]       tri_w;
   logic [SAMPLE_BITS-1:0]       saw_x;
   logic [TURN_W:0]              thr_cmp;
   logic signed [VW-1:0]         alt_raw;
   logic signed [VW-1:0]         alt_sat;
   logic                         is_sine;

   logic                         valid_ff;
   logic                         is_sine_ff;
   logic                         neg_ff;
   logic [RW-1:0]                rom_q_ff;
   logic signed [VW-1:0]         alt_ff;

   logic signed [VW-1:0]         sine_v;
   logic signed [VW-1:0]         sine_sat;

   for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
      assign sine_rom[k] = RW'(sine_entry(k, SINE_TABLE_BITS, SAMPLE_BITS));
   end

   assign quad    = stage.turn[TURN_W-1 -: 2];
   assign idx     = stage.turn[TURN_W-3 -: SINE_TABLE_BITS];
   // odd quadrants run the table backwards
   assign pos     = quad[0] ? (TBL_N_V - {1'b0, idx}) : {1'b0, idx};
   assign tri_w   = stage.turn[TURN_W-2 -: SAMPLE_BITS];
   assign saw_x   = stage.turn[TURN_W-1 -: SAMPLE_BITS];
   assign thr_cmp = {stage.thr, 16'd0};
   assign is_sine = (wave_mode == WAVE_SINE);

   always_comb begin
      case (wave_mode)
         WAVE_TRIANGLE: begin
            if (stage.turn[TURN_W-1]) begin
               alt_raw = FULL_V - $signed({2'b00, tri_w});
            end else begin
               alt_raw = $signed({2'b00, tri_w}) - FULL_V;
            end
         end
         WAVE_RISE_SAW: alt_raw = $signed({2'b00, saw_x}) - FULL_V;
         WAVE_FALL_SAW: alt_raw = FULL_V - $signed({2'b00, saw_x});
         WAVE_SQUARE: begin
            alt_raw = ({1'b0, stage.turn} < thr_cmp) ? -FULL_V : MAX_V;
         end
         default:       alt_raw = '0;
      endcase
      alt_sat = (alt_raw > MAX_V) ? MAX_V : alt_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage.valid;
      end
   end

   // registered rom read plus the side band for the output stage
   always_ff @(posedge clock) begin
      if (advance) begin
         rom_q_ff   <= sine_rom[pos];
         neg_ff     <= quad[1];
         is_sine_ff <= is_sine;
         alt_ff     <= alt_sat;
      end
   end

   always_comb begin
      sine_v   = neg_ff ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});
      sine_sat = (sine_v > MAX_V) ? MAX_V : sine_v;
   end

   assign out_valid  = valid_ff;
   assign out_sample = is_sine_ff ? sine_sat[SAMPLE_BITS-1:0] : alt_ff[SAMPLE_BITS-1:0];

endmodule

>>> rtl/core/multi_waveform_phase_oscillator_top.sv
// Phase-accumulator oscillator: one sample per request, shaped as sine (quarter-wave rom),
// triangle, rising saw, falling saw or square as wave_mode selects. A request is taken every
// cycle while the response side keeps up; the phase add in the accumulator register is the
// loop that sets this rate. An accepted request passes the input register, then the
// registered rom read or shaped value in the output register; when rsp_chan stalls, the whole
// pipeline holds. Change wave_mode only while no response is outstanding.
// depends on mwpo_pkg, mwpo_if, mwpo_csr, mwpo_phase, mwpo_shape
`timescale 1ns / 1ps

module multi_waveform_phase_oscillator_top import mwpo_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   mwpo_req_if.sink              req_chan,
   mwpo_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic                          advance;
   logic [WAVE_MODE_W-1:0]        wave_mode;
   mwpo_stage_type                stage;
   logic                          out_valid;
   logic signed [SAMPLE_BITS-1:0] out_sample;

   // pipeline moves whenever the output register is empty or being drained
   assign advance = !out_valid || rsp_chan.ready;

   mwpo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .wave_mode (wave_mode)
   );

   mwpo_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .stage    (stage)
   );

   mwpo_shape #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_shape (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .advance    (advance),
      .wave_mode  (wave_mode),
      .out_valid  (out_valid),
      .out_sample (out_sample)
   );

   assign rsp_chan.valid  = out_valid;
   assign rsp_chan.sample = out_sample;

   a_accept_loads_stage: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> stage.valid)
      else $error("accepted request did not reach the phase stage");

   a_stage_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && advance) |=> out_valid)
      else $error("phase stage lost on its way to the output");

   a_no_accept_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request accepted while the output is stalled");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (!advance && stage.valid) |=> (stage.valid && $stable(stage.turn)))
      else $error("phase stage changed during a stall");

endmodule
